// ----- hdl/casp_pkg.sv -----
// Package for the cascaded angle/speed PID axis.
// Holds payload, configuration and command types plus fixed-point constants.
// No dependencies.
`default_nettype none

package casp_pkg;

   localparam int FS_W          = 24;
   localparam int LIMIT_W       = 15;
   localparam int GAIN_W        = 16;
   localparam int GAINS_W       = 48;
   localparam int ALPHA_W       = 9;
   localparam int ALPHA_FRAC    = 8;
   localparam int MUL_A_W       = 16;
   localparam int MUL_B_W       = 24;
   localparam int PROD_W        = MUL_A_W + 1 + MUL_B_W;
   localparam int ACC_W         = PROD_W + 1;
   localparam int HALF_TURN     = 25736;
   localparam int FULL_TURN     = 51472;

   localparam logic [GAINS_W-1:0] ANGLE_GAINS_RST    = '0;
   localparam logic [GAINS_W-1:0] SPEED_GAINS_RST    = '0;
   localparam logic [LIMIT_W-1:0] ANGLE_INT_LIM_RST  = 15'd100;
   localparam logic [LIMIT_W-1:0] ANGLE_OUT_LIM_RST  = 15'd300;
   localparam logic [LIMIT_W-1:0] RETURN_LIM_RST     = 15'd100;
   localparam logic [LIMIT_W-1:0] SPEED_INT_LIM_RST  = 15'd10000;
   localparam logic [LIMIT_W-1:0] VOLTAGE_LIM_RST    = 15'd25000;
   localparam logic [ALPHA_W-1:0] ALPHA_RST          = 9'd64;

   typedef struct packed {
      logic signed [15:0] target_angle;
      logic signed [15:0] measured_angle;
      logic signed [15:0] measured_speed;
      logic signed [15:0] feedforward_voltage;
      logic               returning_mode;
      logic               clear_integrals;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_voltage;
      logic signed [15:0] angle_error_out;
      logic signed [15:0] speed_target_out;
   } rsp_type;

   typedef struct packed {
      logic [GAINS_W-1:0] angle_gains;
      logic [GAINS_W-1:0] speed_gains;
      logic [LIMIT_W-1:0] angle_integral_limit;
      logic [LIMIT_W-1:0] angle_output_limit;
      logic [LIMIT_W-1:0] returning_output_limit;
      logic [LIMIT_W-1:0] speed_integral_limit;
      logic [LIMIT_W-1:0] voltage_limit;
      logic [ALPHA_W-1:0] speed_filter_alpha;
   } cfg_type;

   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_ERR     = 4'd1;
   localparam logic [3:0] OP_FILT_LO = 4'd2;
   localparam logic [3:0] OP_FILT_HI = 4'd3;
   localparam logic [3:0] OP_AINT    = 4'd4;
   localparam logic [3:0] OP_APID_P  = 4'd5;
   localparam logic [3:0] OP_APID_D  = 4'd6;
   localparam logic [3:0] OP_ATGT    = 4'd7;
   localparam logic [3:0] OP_SERR    = 4'd8;
   localparam logic [3:0] OP_SDIFF   = 4'd9;
   localparam logic [3:0] OP_SINT    = 4'd10;
   localparam logic [3:0] OP_SPID_P  = 4'd11;
   localparam logic [3:0] OP_SPID_D  = 4'd12;
   localparam logic [3:0] OP_FF      = 4'd13;
   localparam logic [3:0] OP_VOLT    = 4'd14;

   localparam logic [3:0] MUL_NONE     = 4'd0;
   localparam logic [3:0] MUL_FILT_NEW = 4'd1;
   localparam logic [3:0] MUL_FILT_OLD = 4'd2;
   localparam logic [3:0] MUL_AKI      = 4'd3;
   localparam logic [3:0] MUL_AKP      = 4'd4;
   localparam logic [3:0] MUL_AKD      = 4'd5;
   localparam logic [3:0] MUL_SKI      = 4'd6;
   localparam logic [3:0] MUL_SKP      = 4'd7;
   localparam logic [3:0] MUL_SKD      = 4'd8;

   typedef struct packed {
      logic       load;
      logic [3:0] op;
      logic [3:0] mul_sel;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hdl/casp_csr.sv -----
// APB-style configuration register file for the cascaded angle/speed PID axis.
// Depends on casp_pkg for the configuration struct and reset values.
`default_nettype none

module casp_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [5:0]       csr_paddr,
   input  wire logic [63:0]      csr_pwdata,
   output      logic [63:0]      csr_prdata,
   output      logic             csr_pready,
   output      casp_pkg::cfg_type cfg
);

   localparam logic [2:0] REG_ANGLE_GAINS   = 3'd0;
   localparam logic [2:0] REG_SPEED_GAINS   = 3'd1;
   localparam logic [2:0] REG_ANGLE_INT_LIM = 3'd2;
   localparam logic [2:0] REG_ANGLE_OUT_LIM = 3'd3;
   localparam logic [2:0] REG_RETURN_LIM    = 3'd4;
   localparam logic [2:0] REG_SPEED_INT_LIM = 3'd5;
   localparam logic [2:0] REG_VOLTAGE_LIM   = 3'd6;
   localparam logic [2:0] REG_ALPHA         = 3'd7;

   casp_pkg::cfg_type cfg_ff;
   casp_pkg::cfg_type cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ANGLE_GAINS:   cfg_in.angle_gains = csr_pwdata[casp_pkg::GAINS_W-1:0];
            REG_SPEED_GAINS:   cfg_in.speed_gains = csr_pwdata[casp_pkg::GAINS_W-1:0];
            REG_ANGLE_INT_LIM: cfg_in.angle_integral_limit = csr_pwdata[14:0];
            REG_ANGLE_OUT_LIM: cfg_in.angle_output_limit = csr_pwdata[14:0];
            REG_RETURN_LIM:    cfg_in.returning_output_limit = csr_pwdata[14:0];
            REG_SPEED_INT_LIM: cfg_in.speed_integral_limit = csr_pwdata[14:0];
            REG_VOLTAGE_LIM:   cfg_in.voltage_limit = csr_pwdata[14:0];
            REG_ALPHA:         cfg_in.speed_filter_alpha = csr_pwdata[8:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ANGLE_GAINS:   csr_prdata = 64'(cfg_ff.angle_gains);
         REG_SPEED_GAINS:   csr_prdata = 64'(cfg_ff.speed_gains);
         REG_ANGLE_INT_LIM: csr_prdata = 64'(cfg_ff.angle_integral_limit);
         REG_ANGLE_OUT_LIM: csr_prdata = 64'(cfg_ff.angle_output_limit);
         REG_RETURN_LIM:    csr_prdata = 64'(cfg_ff.returning_output_limit);
         REG_SPEED_INT_LIM: csr_prdata = 64'(cfg_ff.speed_integral_limit);
         REG_VOLTAGE_LIM:   csr_prdata = 64'(cfg_ff.voltage_limit);
         REG_ALPHA:         csr_prdata = 64'(cfg_ff.speed_filter_alpha);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_gains            <= casp_pkg::ANGLE_GAINS_RST;
         cfg_ff.speed_gains            <= casp_pkg::SPEED_GAINS_RST;
         cfg_ff.angle_integral_limit   <= casp_pkg::ANGLE_INT_LIM_RST;
         cfg_ff.angle_output_limit     <= casp_pkg::ANGLE_OUT_LIM_RST;
         cfg_ff.returning_output_limit <= casp_pkg::RETURN_LIM_RST;
         cfg_ff.speed_integral_limit   <= casp_pkg::SPEED_INT_LIM_RST;
         cfg_ff.voltage_limit          <= casp_pkg::VOLTAGE_LIM_RST;
         cfg_ff.speed_filter_alpha     <= casp_pkg::ALPHA_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/casp_ctrl.sv -----
// Step sequencer for the cascaded angle/speed PID axis.
// Issues one datapath command per cycle, holding in the last step while the output register is
// still stalled, and owns both handshakes. Depends on casp_pkg for command codes.
`default_nettype none

module casp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      casp_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_ERR     = 4'd1;
   localparam logic [3:0] ST_FILT_LO = 4'd2;
   localparam logic [3:0] ST_FILT_HI = 4'd3;
   localparam logic [3:0] ST_AINT    = 4'd4;
   localparam logic [3:0] ST_APID_P  = 4'd5;
   localparam logic [3:0] ST_APID_D  = 4'd6;
   localparam logic [3:0] ST_ATGT    = 4'd7;
   localparam logic [3:0] ST_SERR    = 4'd8;
   localparam logic [3:0] ST_SDIFF   = 4'd9;
   localparam logic [3:0] ST_SINT    = 4'd10;
   localparam logic [3:0] ST_SPID_P  = 4'd11;
   localparam logic [3:0] ST_SPID_D  = 4'd12;
   localparam logic [3:0] ST_FF      = 4'd13;
   localparam logic [3:0] ST_VOLT    = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.load     = 1'b0;
      cmd.op       = casp_pkg::OP_NONE;
      cmd.mul_sel  = casp_pkg::MUL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.op      = casp_pkg::OP_ERR;
            cmd.mul_sel = casp_pkg::MUL_FILT_NEW;
            state_in    = ST_FILT_LO;
         end
         ST_FILT_LO: begin
            cmd.op      = casp_pkg::OP_FILT_LO;
            cmd.mul_sel = casp_pkg::MUL_FILT_OLD;
            state_in    = ST_FILT_HI;
         end
         ST_FILT_HI: begin
            cmd.op      = casp_pkg::OP_FILT_HI;
            cmd.mul_sel = casp_pkg::MUL_AKI;
            state_in    = ST_AINT;
         end
         ST_AINT: begin
            cmd.op      = casp_pkg::OP_AINT;
            cmd.mul_sel = casp_pkg::MUL_AKP;
            state_in    = ST_APID_P;
         end
         ST_APID_P: begin
            cmd.op      = casp_pkg::OP_APID_P;
            cmd.mul_sel = casp_pkg::MUL_AKD;
            state_in    = ST_APID_D;
         end
         ST_APID_D: begin
            cmd.op   = casp_pkg::OP_APID_D;
            state_in = ST_ATGT;
         end
         ST_ATGT: begin
            cmd.op   = casp_pkg::OP_ATGT;
            state_in = ST_SERR;
         end
         ST_SERR: begin
            cmd.op   = casp_pkg::OP_SERR;
            state_in = ST_SDIFF;
         end
         ST_SDIFF: begin
            cmd.op      = casp_pkg::OP_SDIFF;
            cmd.mul_sel = casp_pkg::MUL_SKI;
            state_in    = ST_SINT;
         end
         ST_SINT: begin
            cmd.op      = casp_pkg::OP_SINT;
            cmd.mul_sel = casp_pkg::MUL_SKP;
            state_in    = ST_SPID_P;
         end
         ST_SPID_P: begin
            cmd.op      = casp_pkg::OP_SPID_P;
            cmd.mul_sel = casp_pkg::MUL_SKD;
            state_in    = ST_SPID_D;
         end
         ST_SPID_D: begin
            cmd.op   = casp_pkg::OP_SPID_D;
            state_in = ST_FF;
         end
         ST_FF: begin
            cmd.op   = casp_pkg::OP_FF;
            state_in = ST_VOLT;
         end
         ST_VOLT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.op       = casp_pkg::OP_VOLT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/casp_dp.sv -----
// Datapath for the cascaded angle/speed PID axis: one shared multiplier,
// accumulator, loop state and output register. Driven by casp_ctrl commands.
// Depends on casp_pkg for types, widths and op codes.
`default_nettype none

module casp_dp #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire casp_pkg::cmd_type cmd,
   input  wire casp_pkg::req_type req_payload,
   input  wire casp_pkg::cfg_type cfg,
   output      casp_pkg::rsp_type rsp_payload
);

   localparam int ACC_W   = casp_pkg::ACC_W;
   localparam int PROD_W  = casp_pkg::PROD_W;
   localparam int FS_W    = casp_pkg::FS_W;
   localparam int GAIN_W  = casp_pkg::GAIN_W;
   localparam int ALPHA_W = casp_pkg::ALPHA_W;
   localparam int AFRAC   = casp_pkg::ALPHA_FRAC;
   localparam logic signed [17:0] HALF_TURN = 18'(casp_pkg::HALF_TURN);
   localparam logic signed [17:0] FULL_TURN = 18'(casp_pkg::FULL_TURN);
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << AFRAC);

   function automatic logic signed [15:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                    input logic [14:0] lim);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'($signed({1'b0, lim}));
      lo = -hi;
      priority if (v > hi) return hi[15:0];
      else if (v < lo)     return lo[15:0];
      else                 return v[15:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] term(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p >>> GAIN_FRAC_BITS;
      return ACC_W'(t);
   endfunction

   // loop state
   logic signed [FS_W-1:0]  fs_ff, fs_in;
   logic signed [15:0]      aprev_ff, aprev_in;
   logic signed [15:0]      ai_ff, ai_in;
   logic signed [16:0]      sprev_ff, sprev_in;
   logic signed [15:0]      si_ff, si_in;

   // working registers
   casp_pkg::req_type       in_ff, in_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [15:0]      err_ff, err_in;
   logic signed [17:0]      diff_ff, diff_in;
   logic signed [16:0]      serr_ff, serr_in;
   logic signed [15:0]      spt_ff, spt_in;
   casp_pkg::rsp_type       rsp_ff, rsp_in;

   logic [ALPHA_W-1:0]      alpha_eff;
   logic [GAIN_W-1:0]       mul_a;
   logic signed [casp_pkg::MUL_B_W-1:0] mul_b;
   logic signed [GAIN_W:0]  mul_a_s;
   logic signed [17:0]      raw_err;
   logic signed [ACC_W-1:0] sum;
   logic [14:0]             tgt_lim;

   assign alpha_eff   = cfg.speed_filter_alpha[ALPHA_W-1] ? ALPHA_ONE
                                                          : cfg.speed_filter_alpha;
   assign mul_a_s     = $signed({1'b0, mul_a});
   assign prod_in     = mul_a_s * mul_b;
   assign rsp_payload = rsp_ff;
   assign tgt_lim     = in_ff.returning_mode ? cfg.returning_output_limit
                                             : cfg.angle_output_limit;

   always_comb begin
      unique case (cmd.mul_sel)
         casp_pkg::MUL_FILT_NEW: begin
            mul_a = GAIN_W'(alpha_eff);
            mul_b = 24'(in_ff.measured_speed);
         end
         casp_pkg::MUL_FILT_OLD: begin
            mul_a = GAIN_W'(ALPHA_ONE - alpha_eff);
            mul_b = fs_ff;
         end
         casp_pkg::MUL_AKI: begin
            mul_a = cfg.angle_gains[31:16];
            mul_b = 24'(err_ff);
         end
         casp_pkg::MUL_AKP: begin
            mul_a = cfg.angle_gains[15:0];
            mul_b = 24'(err_ff);
         end
         casp_pkg::MUL_AKD: begin
            mul_a = cfg.angle_gains[47:32];
            mul_b = 24'(diff_ff);
         end
         casp_pkg::MUL_SKI: begin
            mul_a = cfg.speed_gains[31:16];
            mul_b = 24'(serr_ff);
         end
         casp_pkg::MUL_SKP: begin
            mul_a = cfg.speed_gains[15:0];
            mul_b = 24'(serr_ff);
         end
         casp_pkg::MUL_SKD: begin
            mul_a = cfg.speed_gains[47:32];
            mul_b = 24'(diff_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      fs_in    = fs_ff;
      aprev_in = aprev_ff;
      ai_in    = ai_ff;
      sprev_in = sprev_ff;
      si_in    = si_ff;
      in_in    = in_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      diff_in  = diff_ff;
      serr_in  = serr_ff;
      spt_in   = spt_ff;
      rsp_in   = rsp_ff;
      raw_err  = 18'(in_ff.target_angle) - 18'(in_ff.measured_angle);
      sum      = '0;

      if (cmd.load) begin
         in_in = req_payload;
         if (req_payload.clear_integrals) begin
            ai_in = '0;
            si_in = '0;
         end
      end

      unique case (cmd.op)
         casp_pkg::OP_NONE: begin
         end
         casp_pkg::OP_ERR: begin
            priority if (raw_err > HALF_TURN - 18'sd1) err_in = 16'(raw_err - FULL_TURN);
            else if (raw_err < -HALF_TURN)             err_in = 16'(raw_err + FULL_TURN);
            else                                       err_in = 16'(raw_err);
         end
         casp_pkg::OP_FILT_LO: begin
            acc_in  = ACC_W'(prod_ff) <<< AFRAC;
            diff_in = 18'(err_ff) - 18'(aprev_ff);
         end
         casp_pkg::OP_FILT_HI: begin
            sum   = acc_ff + ACC_W'(prod_ff);
            fs_in = FS_W'(sum >>> AFRAC);
         end
         casp_pkg::OP_AINT: begin
            sum   = ACC_W'(ai_ff) + term(prod_ff);
            ai_in = clamp_sym(sum, cfg.angle_integral_limit);
         end
         casp_pkg::OP_APID_P: acc_in = term(prod_ff) + ACC_W'(ai_ff);
         casp_pkg::OP_APID_D: begin
            acc_in   = acc_ff + term(prod_ff);
            aprev_in = err_ff;
         end
         casp_pkg::OP_ATGT: spt_in = clamp_sym(acc_ff, tgt_lim);
         casp_pkg::OP_SERR: serr_in = 17'(spt_ff) - 17'($signed(fs_ff[FS_W-1:AFRAC]));
         casp_pkg::OP_SDIFF: diff_in = 18'(serr_ff) - 18'(sprev_ff);
         casp_pkg::OP_SINT: begin
            sum   = ACC_W'(si_ff) + term(prod_ff);
            si_in = clamp_sym(sum, cfg.speed_integral_limit);
         end
         casp_pkg::OP_SPID_P: acc_in = term(prod_ff) + ACC_W'(si_ff);
         casp_pkg::OP_SPID_D: begin
            acc_in   = acc_ff + term(prod_ff);
            sprev_in = serr_ff;
         end
         casp_pkg::OP_FF: acc_in = acc_ff + ACC_W'(in_ff.feedforward_voltage);
         casp_pkg::OP_VOLT: begin
            rsp_in.drive_voltage    = clamp_sym(acc_ff, cfg.voltage_limit);
            rsp_in.angle_error_out  = err_ff;
            rsp_in.speed_target_out = spt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff    <= '0;
         aprev_ff <= '0;
         ai_ff    <= '0;
         sprev_ff <= '0;
         si_ff    <= '0;
      end else begin
         fs_ff    <= fs_in;
         aprev_ff <= aprev_in;
         ai_ff    <= ai_in;
         sprev_ff <= sprev_in;
         si_ff    <= si_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      err_ff  <= err_in;
      diff_ff <= diff_in;
      serr_ff <= serr_in;
      spt_ff  <= spt_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- hdl/cascaded_angle_speed_pid_axis.sv -----
// Cascaded angle/speed PID for one gimbal axis: top level.
// A new transaction is taken only after the previous one has run all its steps, which include
// eight products run in turn through the single shared 17x24 multiplier; the last step waits
// while a prior result is still stalled. Reset clears loop state and control, and loads
// register defaults.
// Depends on casp_pkg, casp_csr, casp_ctrl and casp_dp.
`default_nettype none

module cascaded_angle_speed_pid_axis #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire casp_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      casp_pkg::rsp_type rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [5:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output      logic [63:0]       csr_prdata,
   output      logic              csr_pready
);

   casp_pkg::cfg_type cfg;
   casp_pkg::cmd_type cmd;

   casp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   casp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   casp_dp #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .cfg         (cfg),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking bench for cascaded_angle_speed_pid_axis: directed and random control ticks
// with random input gaps and result stalls, checked against a built-in cascaded PID model.
// Depends on casp_pkg and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAIN_FRAC   = 8;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 20;
   localparam int PRINT_LIMIT = 50;

   typedef enum int {
      REG_ANGLE_GAINS,
      REG_SPEED_GAINS,
      REG_ANGLE_INT_LIM,
      REG_ANGLE_OUT_LIM,
      REG_RETURN_LIM,
      REG_SPEED_INT_LIM,
      REG_VOLTAGE_LIM,
      REG_SPEED_ALPHA
   } csr_index_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   casp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   casp_pkg::rsp_type rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [5:0]        csr_paddr   = '0;
   logic [63:0]       csr_pwdata  = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   logic        no_gaps        = 1'b0;
   int unsigned cycle_count    = 0;
   int          mismatch_count = 0;

   casp_pkg::cfg_type cfg;
   longint            filt_speed = 0;
   longint            ang_prev   = 0;
   longint            ang_int    = 0;
   longint            spd_prev   = 0;
   longint            spd_int    = 0;
   casp_pkg::rsp_type pending_cmds[$];
   casp_pkg::rsp_type want_cmd;

   cascaded_angle_speed_pid_axis #(
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || no_gaps) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 33);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d transactions pending", pending_cmds.size());
         $display("cascaded_angle_speed_pid_axis: mismatch");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(input string name, input logic signed [15:0] got,
                              input logic signed [15:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            report_error("result transaction with nothing pending");
         end else begin
            want_cmd = pending_cmds.pop_front();
            check_field("drive_voltage", rsp_payload.drive_voltage, want_cmd.drive_voltage);
            check_field("angle_error_out", rsp_payload.angle_error_out,
                        want_cmd.angle_error_out);
            check_field("speed_target_out", rsp_payload.speed_target_out,
                        want_cmd.speed_target_out);
         end
      end
   end

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint gain_term(input logic [47:0] gains, input int slot,
                                        input longint x);
      longint k;
      k = longint'(gains[16*slot +: 16]);
      return (k * x) >>> GAIN_FRAC;
   endfunction

   function automatic casp_pkg::rsp_type axis_tick(input casp_pkg::req_type t);
      casp_pkg::rsp_type r;
      longint  tgt, meas, spd, ff, alpha, err, tgt_spd, serr, volt, lim;
      tgt  = longint'($signed(t.target_angle));
      meas = longint'($signed(t.measured_angle));
      spd  = longint'($signed(t.measured_speed));
      ff   = longint'($signed(t.feedforward_voltage));
      if (t.clear_integrals) begin
         ang_int = 0;
         spd_int = 0;
      end
      alpha = (cfg.speed_filter_alpha > 9'd256) ? 256 : longint'(cfg.speed_filter_alpha);
      filt_speed = (alpha * spd * 256 + (256 - alpha) * filt_speed) >>> 8;

      err = tgt - meas;
      while (err > casp_pkg::HALF_TURN - 1) err -= casp_pkg::FULL_TURN;
      while (err < -casp_pkg::HALF_TURN) err += casp_pkg::FULL_TURN;

      ang_int = clamp_sym(ang_int + gain_term(cfg.angle_gains, 1, err),
                          cfg.angle_integral_limit);
      tgt_spd = gain_term(cfg.angle_gains, 0, err) + ang_int
              + gain_term(cfg.angle_gains, 2, err - ang_prev);
      ang_prev = err;
      lim = t.returning_mode ? longint'(cfg.returning_output_limit)
                             : longint'(cfg.angle_output_limit);
      tgt_spd = clamp_sym(tgt_spd, lim);

      serr = tgt_spd - (filt_speed >>> 8);
      spd_int = clamp_sym(spd_int + gain_term(cfg.speed_gains, 1, serr),
                          cfg.speed_integral_limit);
      volt = gain_term(cfg.speed_gains, 0, serr) + spd_int
           + gain_term(cfg.speed_gains, 2, serr - spd_prev);
      spd_prev = serr;
      volt = clamp_sym(volt + ff, cfg.voltage_limit);

      r.drive_voltage    = 16'(volt);
      r.angle_error_out  = 16'(err);
      r.speed_target_out = 16'(tgt_spd);
      return r;
   endfunction

   function automatic casp_pkg::req_type tick(input int tgt, input int meas, input int spd,
                                              input int ff, input bit ret, input bit clr);
      casp_pkg::req_type t;
      t.target_angle        = 16'(tgt);
      t.measured_angle      = 16'(meas);
      t.measured_speed      = 16'(spd);
      t.feedforward_voltage = 16'(ff);
      t.returning_mode      = ret;
      t.clear_integrals     = clr;
      return t;
   endfunction

   function automatic casp_pkg::req_type random_tick();
      int base, off, spd, ff;
      if ($urandom_range(99) < 25) begin
         return {$urandom, $urandom, 2'($urandom)};
      end
      base = int'($urandom_range(0, 51471)) - 25736;
      off  = int'($urandom_range(0, 4000)) - 2000;
      spd  = int'($urandom_range(0, 6000)) - 3000;
      ff   = ($urandom_range(3) == 0) ? int'($urandom_range(0, 60000)) - 30000 : 0;
      return tick(base, base - off, spd, ff, $urandom_range(3) == 0,
                  $urandom_range(15) == 0);
   endfunction

   function automatic logic [47:0] random_gains();
      if ($urandom_range(7) == 0) begin
         return {16'($urandom), 32'($urandom)};
      end
      return {16'($urandom_range(0, 511)), 16'($urandom_range(0, 63)),
              16'($urandom_range(0, 1023))};
   endfunction

   function automatic logic [14:0] random_limit();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2, 3: return 15'($urandom);
         default: return 15'($urandom_range(1, 4000));
      endcase
   endfunction

   function automatic casp_pkg::cfg_type random_setting();
      casp_pkg::cfg_type s;
      s.angle_gains            = random_gains();
      s.speed_gains            = random_gains();
      s.angle_integral_limit   = random_limit();
      s.angle_output_limit     = random_limit();
      s.returning_output_limit = random_limit();
      s.speed_integral_limit   = random_limit();
      s.voltage_limit          = random_limit();
      case ($urandom_range(5))
         0: s.speed_filter_alpha = 9'd0;
         1: s.speed_filter_alpha = 9'd256;
         2: s.speed_filter_alpha = 9'h1FF;
         default: s.speed_filter_alpha = 9'($urandom_range(1, 255));
      endcase
      return s;
   endfunction

   task automatic send_tick(input casp_pkg::req_type t);
      while (!no_gaps && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      pending_cmds.push_back(axis_tick(t));
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 6'(8 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic program_regs(input casp_pkg::cfg_type s);
      csr_write(REG_ANGLE_GAINS, 64'(s.angle_gains));
      csr_write(REG_SPEED_GAINS, 64'(s.speed_gains));
      csr_write(REG_ANGLE_INT_LIM, 64'(s.angle_integral_limit));
      csr_write(REG_ANGLE_OUT_LIM, 64'(s.angle_output_limit));
      csr_write(REG_RETURN_LIM, 64'(s.returning_output_limit));
      csr_write(REG_SPEED_INT_LIM, 64'(s.speed_integral_limit));
      csr_write(REG_VOLTAGE_LIM, 64'(s.voltage_limit));
      csr_write(REG_SPEED_ALPHA, 64'(s.speed_filter_alpha));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg = s;
   endtask

   // zero gains: output is the saturated feedforward; also angle wrap both ways
   task automatic test_reset_defaults();
      send_tick(tick(0, 0, 0, 30000, 1'b0, 1'b0));
      send_tick(tick(0, 0, 0, -30000, 1'b0, 1'b0));
      send_tick(tick(25735, -25736, 32767, -32768, 1'b1, 1'b1));
      send_tick(tick(-25736, 25735, -32768, 32767, 1'b0, 1'b0));
      send_tick(tick(32767, -32768, 0, 0, 1'b0, 1'b1));
      wait_quiet();
   endtask

   // filter weight above full scale, integral build-up, returning and clear
   task automatic test_filter_and_gains();
      casp_pkg::cfg_type s;
      s = '{angle_gains: 48'h0100_0010_0200, speed_gains: 48'h0080_0020_0400,
            angle_integral_limit: 15'd500, angle_output_limit: 15'd3000,
            returning_output_limit: 15'd800, speed_integral_limit: 15'd10000,
            voltage_limit: 15'd30000, speed_filter_alpha: 9'h1FF};
      program_regs(s);
      send_tick(tick(8192, 0, 0, 0, 1'b0, 1'b0));
      send_tick(tick(8192, 0, 0, 0, 1'b0, 1'b0));
      send_tick(tick(8192, 0, 1000, 0, 1'b1, 1'b0));
      send_tick(tick(-25736, 25735, -500, 0, 1'b0, 1'b0));
      send_tick(tick(0, 8192, 32767, 0, 1'b0, 1'b1));
      send_tick(tick(-32768, 32767, -32768, -30000, 1'b1, 1'b0));
      send_tick(tick(100, 0, 0, 30000, 1'b0, 1'b0));
      send_tick(tick(0, 0, 0, 0, 1'b0, 1'b1));
      wait_quiet();
   endtask

   task automatic test_limit_extremes();
      casp_pkg::cfg_type s;
      s = '{angle_gains: 48'h0100_0010_0200, speed_gains: 48'h0080_0020_0400,
            angle_integral_limit: '0, angle_output_limit: '0,
            returning_output_limit: '0, speed_integral_limit: '0,
            voltage_limit: '0, speed_filter_alpha: 9'd0};
      program_regs(s);
      send_tick(tick(8192, 0, 5000, 20000, 1'b0, 1'b0));
      send_tick(tick(-8192, 0, -5000, -20000, 1'b1, 1'b0));
      send_tick(tick(32767, 0, 32767, 32767, 1'b0, 1'b1));
      send_tick(tick(-32768, 0, -32768, -32768, 1'b1, 1'b0));
      wait_quiet();
      s = '{angle_gains: '1, speed_gains: '1, angle_integral_limit: '1,
            angle_output_limit: '1, returning_output_limit: '1,
            speed_integral_limit: '1, voltage_limit: '1, speed_filter_alpha: 9'd256};
      program_regs(s);
      send_tick(tick(25735, -25736, -32768, 0, 1'b0, 1'b0));
      send_tick(tick(-25736, 25735, 32767, 0, 1'b1, 1'b0));
      send_tick(tick(1, 0, 0, 32767, 1'b0, 1'b1));
      send_tick(tick(0, 1, 0, -32768, 1'b0, 1'b0));
      wait_quiet();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 11; phase++) begin
         program_regs(random_setting());
         repeat (160) send_tick(random_tick());
         wait_quiet();
      end
   endtask

   task automatic test_back_to_back();
      no_gaps <= 1'b1;
      program_regs(random_setting());
      repeat (170) send_tick(random_tick());
      wait_quiet();
      no_gaps <= 1'b0;
   endtask

   initial begin
      cfg = '{angle_gains: casp_pkg::ANGLE_GAINS_RST,
              speed_gains: casp_pkg::SPEED_GAINS_RST,
              angle_integral_limit: casp_pkg::ANGLE_INT_LIM_RST,
              angle_output_limit: casp_pkg::ANGLE_OUT_LIM_RST,
              returning_output_limit: casp_pkg::RETURN_LIM_RST,
              speed_integral_limit: casp_pkg::SPEED_INT_LIM_RST,
              voltage_limit: casp_pkg::VOLTAGE_LIM_RST,
              speed_filter_alpha: casp_pkg::ALPHA_RST};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_filter_and_gains();
      test_limit_extremes();
      test_random_settings();
      test_back_to_back();

      if (mismatch_count == 0) begin
         $display("cascaded_angle_speed_pid_axis: match");
      end else begin
         $display("cascaded_angle_speed_pid_axis: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/casp_pkg.sv
hdl/casp_csr.sv
hdl/casp_ctrl.sv
hdl/casp_dp.sv
hdl/cascaded_angle_speed_pid_axis.sv
dv/tb_top.sv
